>>> hdl/ase_pkg.sv
// Shared widths, constants and controller/datapath types of the atanh series evaluator.
package ase_pkg;

  localparam int X_W           = 32;
  localparam int TOL_W         = 31;
  localparam int SUM_W         = 36;
  localparam int COUNT_W       = 11;
  localparam int STEP_W        = $clog2(X_W);
  localparam int FRAC_BITS_DEF = 30;
  localparam int MAX_TERMS_DEF = 1024;

  localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(1074);
  localparam logic [SUM_W-1:0]   SUM_MAG_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL1,
    OP_MUL2,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ACC,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic term_ge_tol;
    logic at_max;
  } sts_t;

endpackage

>>> hdl/ase_in_if.sv
// Request channel carrying one fixed-point argument.
interface ase_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [ase_pkg::X_W-1:0]  x_value;

  modport source (output valid, output x_value, input ready);
  modport sink (input valid, input x_value, output ready);
endinterface

>>> hdl/ase_out_if.sv
// Result channel carrying the series sum, term count and flags.
interface ase_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ase_pkg::SUM_W-1:0]    series_sum;
  logic        [ase_pkg::COUNT_W-1:0]  term_count;
  logic                                out_of_range;
  logic                                limit_hit;

  modport source (output valid, output series_sum, output term_count,
                  output out_of_range, output limit_hit, input ready);
  modport sink (input valid, input series_sum, input term_count,
                input out_of_range, input limit_hit, output ready);
endinterface

>>> hdl/ase_dpath.sv
// Datapath: power multiplier, serial divider, accumulator and result registers.
module ase_dpath #(
  parameter int FRAC_BITS = ase_pkg::FRAC_BITS_DEF,
  parameter int MAX_TERMS = ase_pkg::MAX_TERMS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [ase_pkg::X_W-1:0]      x_value_i,
  input  logic                                cfg_we_i,
  input  logic        [ase_pkg::TOL_W-1:0]    cfg_data_i,
  input  ase_pkg::cmd_t                       cmd_i,
  output ase_pkg::sts_t                       sts_o,
  output logic signed [ase_pkg::SUM_W-1:0]    series_sum_o,
  output logic        [ase_pkg::COUNT_W-1:0]  term_count_o,
  output logic                                out_of_range_o,
  output logic                                limit_hit_o
);

  localparam int XW    = ase_pkg::X_W;
  localparam int NW    = $clog2(MAX_TERMS + 1);
  localparam int DW    = NW + 1;
  localparam int ACC_W = XW + $clog2(MAX_TERMS + 2);
  localparam int CW    = (NW > ase_pkg::COUNT_W) ? NW : ase_pkg::COUNT_W;

  logic [ase_pkg::TOL_W-1:0] tol_q;
  logic [XW-1:0]             mag_q;
  logic [XW-1:0]             pw_q;
  logic [2*XW-1:0]           prod_q;
  logic [XW-1:0]             quo_q;
  logic [DW-1:0]             rem_q;
  logic [DW-1:0]             div_q;
  logic [ACC_W-1:0]          acc_q;
  logic [NW-1:0]             n_q;
  logic                      neg_q;
  logic                      oor_q;
  logic                      lim_q;

  logic [XW-1:0]             x_u;
  logic [XW-1:0]             mag_in;
  logic [XW-1:0]             pw_shift;
  logic [XW-1:0]             mul_a;
  logic [2*XW-1:0]           mul_res;
  logic [DW:0]               trial;
  logic                      trial_ge;
  logic [ase_pkg::SUM_W-1:0] sat_mag;
  logic [ase_pkg::SUM_W-1:0] signed_sum;
  logic [CW-1:0]             n_ext;

  assign x_u      = x_value_i;
  assign mag_in   = x_u[XW-1] ? (~x_u + XW'(1)) : x_u;
  assign pw_shift = XW'(prod_q >> FRAC_BITS);
  assign mul_a    = (cmd_i.op == ase_pkg::OP_MUL1) ? pw_q : pw_shift;
  assign mul_res  = mul_a * mag_q;
  assign trial    = {rem_q, quo_q[XW-1]};
  assign trial_ge = trial >= {1'b0, div_q};

  assign sat_mag    = (acc_q > ACC_W'(ase_pkg::SUM_MAG_MAX)) ? ase_pkg::SUM_MAG_MAX
                                                              : ase_pkg::SUM_W'(acc_q);
  assign signed_sum = neg_q ? (~sat_mag + ase_pkg::SUM_W'(1)) : sat_mag;
  assign n_ext      = CW'(n_q);

  assign sts_o.oor         = oor_q;
  assign sts_o.term_ge_tol = quo_q >= {1'b0, tol_q};
  assign sts_o.at_max      = n_q == NW'(MAX_TERMS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= ase_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ase_pkg::OP_LOAD: begin
        neg_q <= x_u[XW-1];
        mag_q <= mag_in;
        pw_q  <= mag_in;
        acc_q <= ACC_W'(mag_in);
        n_q   <= '0;
        lim_q <= 1'b0;
        oor_q <= (mag_in >> FRAC_BITS) != '0;
      end
      ase_pkg::OP_MUL1: begin
        n_q    <= n_q + NW'(1);
        prod_q <= mul_res;
      end
      ase_pkg::OP_MUL2: begin
        prod_q <= mul_res;
      end
      ase_pkg::OP_DIV_INIT: begin
        pw_q  <= pw_shift;
        quo_q <= pw_shift;
        rem_q <= '0;
        div_q <= {n_q, 1'b1};
      end
      ase_pkg::OP_DIV_STEP: begin
        rem_q <= trial_ge ? DW'(trial - {1'b0, div_q}) : DW'(trial);
        quo_q <= {quo_q[XW-2:0], trial_ge};
      end
      ase_pkg::OP_ACC: begin
        acc_q <= acc_q + ACC_W'(quo_q);
        lim_q <= sts_o.term_ge_tol;
      end
      ase_pkg::OP_OUT: begin
        series_sum_o   <= oor_q ? '0 : signed_sum;
        term_count_o   <= (n_ext > CW'(ase_pkg::COUNT_MAX)) ? ase_pkg::COUNT_MAX
                                                            : ase_pkg::COUNT_W'(n_ext);
        out_of_range_o <= oor_q;
        limit_hit_o    <= lim_q;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ase_pkg::OP_ACC) |-> (rem_q < div_q))
    else $error("Division remainder is not below the divisor.");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ase_pkg::OP_MUL1) |-> (n_q < NW'(MAX_TERMS)))
    else $error("Term count would pass its limit.");

  a_oor_no_terms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ase_pkg::OP_OUT && oor_q) |-> (n_q == '0))
    else $error("Out-of-range request added series terms.");
`endif

endmodule

>>> hdl/ase_ctrl.sv
// Controller: sequences load, the per-term multiply/divide/accumulate loop and output.
module ase_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ase_pkg::sts_t  sts_i,
  output ase_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_DINIT = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_ACC   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  localparam logic [ase_pkg::STEP_W-1:0] STEP_LAST = ase_pkg::STEP_W'(ase_pkg::X_W - 1);

  logic [2:0]                  state_q, state_d;
  logic [ase_pkg::STEP_W-1:0]  step_q, step_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_free;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = ase_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = ase_pkg::OP_LOAD;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        state_d = sts_i.oor ? S_FIN : S_MUL1;
      end
      S_MUL1: begin
        cmd_o.op = ase_pkg::OP_MUL1;
        state_d  = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.op = ase_pkg::OP_MUL2;
        state_d  = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.op = ase_pkg::OP_DIV_INIT;
        step_d   = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = ase_pkg::OP_DIV_STEP;
        step_d   = step_q + ase_pkg::STEP_W'(1);
        if (step_q == STEP_LAST) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.op = ase_pkg::OP_ACC;
        state_d  = (sts_i.term_ge_tol && !sts_i.at_max) ? S_MUL1 : S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.op    = ase_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_div_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && step_q == STEP_LAST) |=> (state_q == S_ACC))
    else $error("Divider did not finish after the last step.");

  a_chk_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> $past(in_valid_i && in_ready_o))
    else $error("Range check entered without an accepted request.");

  a_fin_publishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("Finished result was not published to a free output.");
`endif

endmodule

>>> hdl/atanh_series_evaluator_top.sv
// Top level of the atanh series evaluator: controller, datapath and channel wiring.
//
//   Channel  Direction  Contents
//   in_req   sink       x_value (signed, FRAC_BITS fraction bits)
//   out_rsp  source     series_sum, term_count, out_of_range, limit_hit
//   cfg      write      tolerance (cfg_we_i, cfg_data_i)
//
// A request passes through load and range check, then through each term
// (two registered multiplies, divider setup, 32 one-bit restoring divide steps
// and the accumulate), then through the write of the output register.
// The serial divider is 32 bits wide; an out-of-range argument skips the term
// loop and goes to the output write. A new request is taken while a result waits.
// Reset is asynchronous, active low, and sets the tolerance to 1074.
module atanh_series_evaluator_top #(
  parameter int FRAC_BITS = ase_pkg::FRAC_BITS_DEF,
  parameter int MAX_TERMS = ase_pkg::MAX_TERMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ase_in_if.sink                            in_req,
  ase_out_if.source                         out_rsp,
  input  logic                              cfg_we_i,
  input  logic [ase_pkg::TOL_W-1:0]         cfg_data_i
);

  ase_pkg::cmd_t cmd;
  ase_pkg::sts_t sts;

  ase_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_req.valid),
    .in_ready_o  (in_req.ready),
    .out_valid_o (out_rsp.valid),
    .out_ready_i (out_rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ase_dpath #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_TERMS (MAX_TERMS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .x_value_i      (in_req.x_value),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .series_sum_o   (out_rsp.series_sum),
    .term_count_o   (out_rsp.term_count),
    .out_of_range_o (out_rsp.out_of_range),
    .limit_hit_o    (out_rsp.limit_hit)
  );

endmodule
